[rtl/dbw_pkg.sv]
package dbw_pkg;

  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam int FRAC = 30;
  // biased value: up to about +-18.0 in Q.30
  localparam int XW = 37;
  localparam int AW = 36;

  localparam logic [30:0]   ONE_Q     = 31'h4000_0000;
  localparam logic [63:0]   HALF_LSB  = 64'h0000_0000_2000_0000;
  localparam logic [AW-1:0] HALF_PI_Q = 36'd1686629713;
  localparam logic [AW-1:0] PI_Q      = 36'd3373259426;
  localparam logic [AW-1:0] TWO_PI_Q  = 36'd6746518852;
  localparam logic [AW-1:0] FOUR_PI_Q = 36'd13493037704;

  localparam int HORNER_STEPS = 5;
  // sum of stages in the front (6), Horner steps (5 of 3 each) and shaper (10)
  localparam int PIPE_LATENCY = 31;

  localparam logic [15:0] RST_INPUT_GAIN  = 16'd4096;
  localparam logic [15:0] RST_BIAS_OFFSET = 16'd24576;
  localparam logic [15:0] RST_TRIM_GAIN   = 16'd4096;

  typedef enum logic [1:0] {
    CFG_INPUT_GAIN  = 2'd0,
    CFG_BIAS_OFFSET = 2'd1,
    CFG_TRIM_GAIN   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] input_gain;
    logic [15:0] bias_offset;
    logic [15:0] trim_gain;
  } cfg_t;

  // per-item sideband that rides along the sine pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic               neg;
    logic               sflag;
    logic [30:0]        r;
  } side_t;

  function automatic int horner_div(input int i);
    int k;
    case (i)
      0:       k = 110;
      1:       k = 72;
      2:       k = 42;
      3:       k = 20;
      default: k = 6;
    endcase
    return k;
  endfunction

endpackage

[rtl/dbw_front.sv]
module dbw_front #(
  parameter int SW = dbw_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] in_sample,
  input  dbw_pkg::cfg_t        cfg,
  output logic                 out_valid,
  output logic [31:0]          out_r2,
  output dbw_pkg::side_t       out_side
);
  import dbw_pkg::*;

  localparam int SHIFT = SW - 16;
  localparam int VW = SW + 24;
  localparam logic signed [VW-1:0] RND = (VW'(1) << SHIFT) >> 1;
  localparam logic signed [XW-1:0] ONE_X = XW'(64'd1 << FRAC);

  logic [6:1] vld_r, vld_nxt;

  logic signed [SW+16:0] prod_r, prod_nxt;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic [AW-1:0]         a1_r, a1_nxt;
  side_t                 sd3_r, sd3_nxt, sd4_r, sd4_nxt, sd5_r, sd6_r;
  logic [61:0]           rr_r, rr_nxt;
  logic [31:0]           r2_r, r2_nxt;

  logic signed [VW-1:0]  v, vr, sh;
  logic signed [XW-1:0]  ax;
  logic [AW-1:0]         a, a2;

  always_comb begin
    vld_nxt = {vld_r[5:1], in_valid};

    // stage 1: input gain
    prod_nxt = in_sample * $signed({1'b0, cfg.input_gain});

    // stage 2: to Q.30 with rounding, add bias
    v = {{4{prod_r[SW+16]}}, prod_r, 3'b000};
    vr = v + RND;
    sh = vr >>> SHIFT;
    x_nxt = sh[XW-1:0] + XW'({cfg.bias_offset, 15'b0});

    // stage 3: magnitude, reduce modulo 2*pi
    ax = x_r[XW-1] ? -x_r : x_r;
    a = ax[AW-1:0];
    sd3_nxt.x = x_r[31:0];
    sd3_nxt.neg = x_r[XW-1];
    sd3_nxt.sflag = (x_r > ONE_X) || (x_r < -ONE_X);
    sd3_nxt.r = '0;
    if (a >= FOUR_PI_Q) begin
      a1_nxt = a - FOUR_PI_Q;
    end else if (a >= TWO_PI_Q) begin
      a1_nxt = a - TWO_PI_Q;
    end else begin
      a1_nxt = a;
    end

    // stage 4: fold into [0, pi/2]
    sd4_nxt = sd3_r;
    a2 = a1_r;
    if (a1_r > PI_Q) begin
      a2 = a1_r - PI_Q;
      sd4_nxt.neg = ~sd3_r.neg;
    end
    if (a2 > HALF_PI_Q) begin
      a2 = PI_Q - a2;
    end
    sd4_nxt.r = a2[30:0];

    // stage 5/6: r^2
    rr_nxt = sd4_r.r * sd4_r.r;
    r2_nxt = 32'((64'(rr_r) + HALF_LSB) >> FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    prod_r <= prod_nxt;
    x_r    <= x_nxt;
    a1_r   <= a1_nxt;
    sd3_r  <= sd3_nxt;
    sd4_r  <= sd4_nxt;
    rr_r   <= rr_nxt;
    sd5_r  <= sd4_r;
    r2_r   <= r2_nxt;
    sd6_r  <= sd5_r;
  end

  assign out_valid = vld_r[6];
  assign out_r2    = r2_r;
  assign out_side  = sd6_r;

endmodule

[rtl/dbw_hstep.sv]
module dbw_hstep #(
  parameter int K = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [31:0]    in_r2,
  input  logic [30:0]    in_h,
  input  dbw_pkg::side_t in_side,
  output logic           out_valid,
  output logic [31:0]    out_r2,
  output logic [30:0]    out_h,
  output dbw_pkg::side_t out_side
);
  import dbw_pkg::*;

  // reciprocal with 32-bit multiplier; quotient low by at most one
  localparam int RSH = 31 + $clog2(K);
  localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / K);
  localparam logic [32:0] KHALF = 33'(K / 2);
  localparam logic [33:0] KW = 34'(K);

  logic [3:1]  vld_r, vld_nxt;
  logic [62:0] p_r, p_nxt;
  logic [64:0] qm_r, qm_nxt;
  logic [32:0] n_r, n_nxt;
  logic [31:0] r2a_r, r2b_r, r2c_r;
  side_t       sda_r, sdb_r, sdc_r;
  logic [30:0] h_r, h_nxt;

  logic [32:0] q0, q;
  logic [33:0] rem;
  logic [32:0] hw;

  always_comb begin
    vld_nxt = {vld_r[2:1], in_valid};
    p_nxt = in_r2 * in_h;
    n_nxt = 33'((64'(p_r) + HALF_LSB) >> FRAC) + KHALF;
    qm_nxt = n_nxt * RECIP;
    q0 = 33'(qm_r >> RSH);
    rem = 34'(n_r) - 34'(q0) * KW;
    q = (rem >= KW) ? q0 + 33'd1 : q0;
    hw = 33'(ONE_Q) - q;
    h_nxt = hw[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    p_r   <= p_nxt;
    r2a_r <= in_r2;
    sda_r <= in_side;
    qm_r  <= qm_nxt;
    n_r   <= n_nxt;
    r2b_r <= r2a_r;
    sdb_r <= sda_r;
    h_r   <= h_nxt;
    r2c_r <= r2b_r;
    sdc_r <= sdb_r;
  end

  assign out_valid = vld_r[3];
  assign out_r2    = r2c_r;
  assign out_h     = h_r;
  assign out_side  = sdc_r;

endmodule

[rtl/dbw_shaper.sv]
module dbw_shaper #(
  parameter int SW = dbw_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [30:0]          in_h,
  input  dbw_pkg::side_t       in_side,
  input  dbw_pkg::cfg_t        cfg,
  output logic                 out_valid,
  output logic signed [SW-1:0] out_sample,
  output logic                 out_clipped
);
  import dbw_pkg::*;

  localparam int RSH10 = 34;
  localparam logic [31:0] RECIP10 = 32'((64'd1 << RSH10) / 10);
  localparam int OS = 43 - SW;
  localparam int TW = 50;
  localparam logic signed [TW-1:0] RND = (TW'(1) << OS) >> 1;
  localparam logic signed [TW-1:0] SMAX_W = TW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [TW-1:0] SMIN_W = -SMAX_W - TW'(1);

  logic [9:1] vld_r, vld_nxt;

  logic [61:0]        sp_r, sp_nxt;
  side_t              sd1_r;
  logic signed [31:0] xs_r, xs_nxt, xs3_r, xs4_r, xs5_r, xs6_r, xs7_r;
  logic [30:0]        m_r, m_nxt, m3_r, m4_r;
  logic [61:0]        mm_r, m4p_r, m4p_nxt, m5p_r, m5p_nxt;
  logic [32:0]        n_r, n_nxt;
  logic [64:0]        qm_r, qm_nxt;
  logic [30:0]        t_r, t_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic signed [TW-1:0] tp_r, tp_nxt;
  logic signed [SW-1:0] sample_r, sample_nxt;
  logic               clip_r, clip_nxt;
  logic               ov_r;

  logic [30:0]        s, m2, m4, m5;
  logic signed [31:0] sv, am;
  logic [32:0]        q0, q;
  logic [33:0]        rem;
  logic signed [32:0] y;
  logic signed [TW-1:0] vr, o;

  always_comb begin
    vld_nxt = {vld_r[8:1], in_valid};

    // stage 1: sine = r*h
    sp_nxt = in_side.r * in_h;

    // stage 2: pick sine or the biased value, magnitude
    s = 31'((64'(sp_r) + HALF_LSB) >> FRAC);
    sv = $signed({1'b0, s});
    if (sd1_r.neg) begin
      sv = -sv;
    end
    xs_nxt = sd1_r.sflag ? sv : sd1_r.x;
    am = xs_nxt[31] ? -xs_nxt : xs_nxt;
    m_nxt = am[30:0];

    // stages 3..5: |x|^2, |x|^4, |x|^5
    m2 = 31'((64'(mm_r) + HALF_LSB) >> FRAC);
    m4p_nxt = m2 * m2;
    m4 = 31'((64'(m4p_r) + HALF_LSB) >> FRAC);
    m5p_nxt = m4 * m4_r;

    // stage 6: (2*m5 + 5) / 10 by reciprocal
    m5 = 31'((64'(m5p_r) + HALF_LSB) >> FRAC);
    n_nxt = {1'b0, m5, 1'b0} + 33'd5;
    qm_nxt = n_nxt * RECIP10;

    // stage 7: quotient correction
    q0 = 33'(qm_r >> RSH10);
    rem = 34'(n_r) - 34'(q0) * 34'd10;
    q = (rem >= 34'd10) ? q0 + 33'd1 : q0;
    t_nxt = q[30:0];

    // stage 8: x - 0.2*x^5 toward zero, remove bias
    if (xs7_r[31]) begin
      y = 33'(xs7_r) + $signed({2'b00, t_r});
    end else begin
      y = 33'(xs7_r) - $signed({2'b00, t_r});
    end
    d_nxt = y - $signed({2'b00, cfg.bias_offset, 15'b0});

    // stage 9: trim gain
    tp_nxt = d_r * $signed({1'b0, cfg.trim_gain});

    // stage 10: round to sample format and saturate
    vr = tp_r + RND;
    o = vr >>> OS;
    clip_nxt = 1'b0;
    if (o > SMAX_W) begin
      sample_nxt = SMAX_W[SW-1:0];
      clip_nxt = vld_r[9];
    end else if (o < SMIN_W) begin
      sample_nxt = SMIN_W[SW-1:0];
      clip_nxt = vld_r[9];
    end else begin
      sample_nxt = o[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ov_r   <= 1'b0;
      clip_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      ov_r   <= vld_r[9];
      clip_r <= clip_nxt;
    end
    sp_r     <= sp_nxt;
    sd1_r    <= in_side;
    xs_r     <= xs_nxt;
    m_r      <= m_nxt;
    mm_r     <= m_r * m_r;
    xs3_r    <= xs_r;
    m3_r     <= m_r;
    m4p_r    <= m4p_nxt;
    xs4_r    <= xs3_r;
    m4_r     <= m3_r;
    m5p_r    <= m5p_nxt;
    xs5_r    <= xs4_r;
    n_r      <= n_nxt;
    qm_r     <= qm_nxt;
    xs6_r    <= xs5_r;
    t_r      <= t_nxt;
    xs7_r    <= xs6_r;
    d_r      <= d_nxt;
    tp_r     <= tp_nxt;
    sample_r <= sample_nxt;
  end

  assign out_valid   = ov_r;
  assign out_sample  = sample_r;
  assign out_clipped = clip_r;

endmodule

[rtl/dc_biased_waveshaper_unit.sv]
// DC-biased waveshaper, one signed Q1.(SAMPLE_WIDTH-1) sample per item.
// Input: an item is taken at each rising edge with start high and busy low.
//   busy is always low, so a new sample may be offered every clock.
// Output: out_valid is high for one cycle per item with out_sample_out and
//   out_clipped; the receiver cannot stall, so results simply stream out.
// Pipeline from the accepting edge to the out_valid cycle:
//   6 front stages (gain, bias, range reduction, r^2), 3 per Horner step
//   of the sine series (5 steps), 10 shaper stages (powers, /10, trim, sat).
// Throughput: one item per clock; every multiplier is registered.
// Sine is computed for every item and used only when |x| > 1.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 input gain, 1 bias, 2 trim); other indexes are ignored. Change it only
//   while no items are in flight.
// Reset (synchronous, rst_n low): registers return to unity gains and a
//   0.75 bias, and all items in flight are dropped.
module dc_biased_waveshaper_unit #(
  parameter int SAMPLE_WIDTH = dbw_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                           out_clipped,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import dbw_pkg::*;

  logic [15:0] input_gain_r, input_gain_nxt;
  logic [15:0] bias_offset_r, bias_offset_nxt;
  logic [15:0] trim_gain_r, trim_gain_nxt;
  cfg_t        cfg;

  logic        stp_valid [HORNER_STEPS+1];
  logic [31:0] stp_r2    [HORNER_STEPS+1];
  logic [30:0] stp_h     [HORNER_STEPS+1];
  side_t       stp_side  [HORNER_STEPS+1];

  always_comb begin
    input_gain_nxt  = input_gain_r;
    bias_offset_nxt = bias_offset_r;
    trim_gain_nxt   = trim_gain_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_INPUT_GAIN:  input_gain_nxt  = cfg_wdata;
        CFG_BIAS_OFFSET: bias_offset_nxt = cfg_wdata;
        CFG_TRIM_GAIN:   trim_gain_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_gain_r  <= RST_INPUT_GAIN;
      bias_offset_r <= RST_BIAS_OFFSET;
      trim_gain_r   <= RST_TRIM_GAIN;
    end else begin
      input_gain_r  <= input_gain_nxt;
      bias_offset_r <= bias_offset_nxt;
      trim_gain_r   <= trim_gain_nxt;
    end
  end

  assign cfg.input_gain  = input_gain_r;
  assign cfg.bias_offset = bias_offset_r;
  assign cfg.trim_gain   = trim_gain_r;
  assign busy = 1'b0;

  dbw_front #(.SW(SAMPLE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_sample (in_sample_in),
    .cfg       (cfg),
    .out_valid (stp_valid[0]),
    .out_r2    (stp_r2[0]),
    .out_side  (stp_side[0])
  );

  assign stp_h[0] = ONE_Q;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    dbw_hstep #(.K(horner_div(i))) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stp_valid[i]),
      .in_r2     (stp_r2[i]),
      .in_h      (stp_h[i]),
      .in_side   (stp_side[i]),
      .out_valid (stp_valid[i+1]),
      .out_r2    (stp_r2[i+1]),
      .out_h     (stp_h[i+1]),
      .out_side  (stp_side[i+1])
    );
  end

  dbw_shaper #(.SW(SAMPLE_WIDTH)) u_shaper (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (stp_valid[HORNER_STEPS]),
    .in_h        (stp_h[HORNER_STEPS]),
    .in_side     (stp_side[HORNER_STEPS]),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_sample  (out_sample_out),
    .out_clipped (out_clipped)
  );

endmodule

[rtl/dbw_checker.sv]
module dbw_checker #(
  parameter int SW = dbw_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic signed [SW-1:0] out_sample_out,
  input logic                 out_clipped
);
  import dbw_pkg::*;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  // every result traces back to an item taken exactly one latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, PIPE_LATENCY))
    else $error("result without a matching item");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (out_sample_out == SMAX || out_sample_out == SMIN))
    else $error("clipped result not at a rail");

  a_clip_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_clipped)
    else $error("clipped flag outside a result cycle");

  a_reset_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind dc_biased_waveshaper_unit dbw_checker #(.SW(SAMPLE_WIDTH)) u_dbw_checker (.*);

[verif/tb_dc_biased_waveshaper_unit.sv]
module tb_dc_biased_waveshaper_unit;
  import dbw_pkg::*;

  localparam int SW = 24;
  localparam longint UNITY = 64'sd1 << 30;
  localparam longint unsigned PI_U = 64'd3373259426;
  localparam longint unsigned TWO_PI_U = 64'd6746518852;
  localparam longint unsigned HALF_PI_U = 64'd1686629713;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [SW-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] SMP_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clip;
  } shaped_t;

  logic clk, rst_n, start, busy, out_valid, out_clipped, cfg_we;
  logic signed [SW-1:0] in_sample_in, out_sample_out;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  logic [15:0] gain_in, bias_q15, gain_trim;
  shaped_t shaped_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int clips_seen = 0;
  int cycles = 0;

  dc_biased_waveshaper_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_in(in_sample_in), .out_valid(out_valid),
    .out_sample_out(out_sample_out), .out_clipped(out_clipped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint unsigned mul_frac(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint sine_frac(longint v);
    longint unsigned a, r2, h, s;
    longint unsigned divs[5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    bit neg;
    neg = v < 0;
    a = neg ? longint'(-v) : longint'(v);
    a = a % TWO_PI_U;
    if (a > PI_U) begin
      a = a - PI_U;
      neg = !neg;
    end
    if (a > HALF_PI_U) a = PI_U - a;
    r2 = mul_frac(a, a);
    h = UNITY;
    for (int i = 0; i < 5; i++)
      h = UNITY - (mul_frac(r2, h) + divs[i] / 2) / divs[i];
    s = mul_frac(a, h);
    return neg ? -longint'(s) : longint'(s);
  endfunction

  function automatic shaped_t shape_sample(logic signed [SW-1:0] smp);
    longint s, x, bias, y, m, m5, t, d, o;
    shaped_t r;
    s = longint'(smp);
    x = (s * longint'(gain_in) * 8 + 64'sd128) >>> 8;
    bias = longint'(bias_q15) <<< 15;
    x = x + bias;
    if (x > UNITY || x < -UNITY) x = sine_frac(x);
    m = x < 0 ? -x : x;
    m5 = mul_frac(mul_frac(mul_frac(m, m), mul_frac(m, m)), m);
    t = (m5 * 2 + 5) / 10;
    y = x < 0 ? x + t : x - t;
    d = y - bias;
    o = (d * longint'(gain_trim) + (64'sd1 <<< 18)) >>> 19;
    r.clip = 1'b0;
    if (o > longint'(SMP_MAX)) begin
      o = SMP_MAX;
      r.clip = 1'b1;
    end else if (o < longint'(SMP_MIN)) begin
      o = SMP_MIN;
      r.clip = 1'b1;
    end
    r.sample = o[SW-1:0];
    return r;
  endfunction

  // results cannot be held off, so check every strobe
  always @(posedge clk) begin
    shaped_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_clipped) clips_seen++;
      if (shaped_q.size() == 0) begin
        $error("result with no item pending: sample_out %0d", out_sample_out);
        errors++;
      end else begin
        exp_r = shaped_q.pop_front();
        if (out_sample_out !== exp_r.sample) begin
          $error("sample_out expected %0d actual %0d", exp_r.sample, out_sample_out);
          errors++;
        end
        if (out_clipped !== exp_r.clip) begin
          $error("clipped expected %0d actual %0d", exp_r.clip, out_clipped);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(logic signed [SW-1:0] smp, int gap);
    start = 1'b1;
    in_sample_in = smp;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    shaped_q = {shaped_q, shape_sample(smp)};
    items_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      in_sample_in = SW'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (shaped_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_INPUT_GAIN:  gain_in = val;
      CFG_BIAS_OFFSET: bias_q15 = val;
      CFG_TRIM_GAIN:   gain_trim = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] g, logic [15:0] b, logic [15:0] tr);
    wait_drain();
    write_reg(CFG_INPUT_GAIN, g);
    write_reg(CFG_BIAS_OFFSET, b);
    write_reg(CFG_TRIM_GAIN, tr);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return $signed(24'($urandom_range(0, 255)) - 24'd128);
      3: return $signed(24'($urandom_range(0, 65535)) - 24'd32768);
      default: return SW'($urandom);
    endcase
  endfunction

  // reset values, field extremes, back to back
  task automatic test_reset_state();
    logic signed [SW-1:0] pts[8] = '{SMP_MAX, SMP_MIN, 24'sd0, 24'sd1, -24'sd1,
                                     24'sh400000, -24'sh400000, 24'sh555555};
    foreach (pts[i]) send_sample(pts[i], 0);
  endtask

  task automatic test_special_cases();
    // exactly +-1 after gain, zero bias: no sine; just above one: sine
    set_all(16'd8192, 16'd0, 16'd4096);
    send_sample(24'sh400000, 1);
    send_sample(-24'sh400000, 0);
    send_sample(24'sh400001, 2);
    // bias of exactly one, and beyond one with no clamp
    set_all(16'd4096, 16'd32768, 16'd4096);
    send_sample(24'sd0, 0);
    send_sample(24'sd1, 0);
    wait_drain();
    write_reg(CFG_BIAS_OFFSET, 16'hFFFF);
    send_sample(SMP_MAX, 0);
    send_sample(SMP_MIN, 3);
    // heavy trim forces saturation both ways
    set_all(16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(SMP_MAX, 0);
    send_sample(SMP_MIN, 0);
    send_sample(24'sh100000, 0);
    // spare index must change nothing
    wait_drain();
    write_reg(CFG_SPARE_IDX, 16'h1234);
    send_sample(-24'sh100000, 0);
    set_all(16'd0, 16'd0, 16'd0);
    send_sample(SMP_MAX, 0);
    send_sample(SMP_MIN, 0);
  endtask

  task automatic test_random_phases();
    logic [15:0] g, b, tr;
    int burst;
    for (int ph = 0; ph < 8; ph++) begin
      g = (ph % 3 == 0) ? 16'hFFFF : 16'($urandom_range(0, 16384));
      b = (ph == 1) ? 16'd0 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(24576, 32768));
      tr = (ph == 4) ? 16'hFFFF : (ph == 5) ? 16'd0 : 16'($urandom_range(0, 16384));
      set_all(g, b, tr);
      if (ph == 3) write_reg(CFG_SPARE_IDX, 16'($urandom));
      burst = 0;
      for (int k = 0; k < 110; k++) begin
        if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(5, 30);
        if (k == 55 && ph == 6) wait_drain();
        send_sample(pick_sample(), burst > 0 ? 0 : $urandom_range(0, 13));
        if (burst > 0) burst--;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_sample_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_INPUT_GAIN;
    cfg_wdata = '0;
    gain_in = RST_INPUT_GAIN;
    bias_q15 = RST_BIAS_OFFSET;
    gain_trim = RST_TRIM_GAIN;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_state();
    test_special_cases();
    test_random_phases();
    start = 1'b0;
    while (shaped_q.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    if (shaped_q.size() != 0) begin
      $error("%0d expected results never arrived", shaped_q.size());
      errors++;
    end
    $display("sent %0d items over reset, edge and random gain/bias/trim settings;",
             items_sent);
    $display("checked %0d results, %0d saturated, %0d mismatches",
             results_seen, clips_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dbw_pkg.sv
rtl/dbw_front.sv
rtl/dbw_hstep.sv
rtl/dbw_shaper.sv
rtl/dc_biased_waveshaper_unit.sv
rtl/dbw_checker.sv
verif/tb_dc_biased_waveshaper_unit.sv
